// File: rtl/core/ctfc_pkg.sv
// Shared types, constants, microcode table and byte functions of the frame check unit.
package ctfc_pkg;

  localparam int unsigned TrailerLen = 13;
  localparam int unsigned PcW        = 3;
  localparam int unsigned CountW     = 5;

  localparam logic [7:0]  ChLbrace = 8'h7B;
  localparam logic [7:0]  ChRbrace = 8'h7D;
  localparam logic [7:0]  ChLf     = 8'h0A;
  localparam logic [7:0]  ChCr     = 8'h0D;
  localparam logic [7:0]  ChQuote  = 8'h22;
  localparam logic [7:0]  ChColon  = 8'h3A;
  localparam logic [7:0]  ChLowC   = 8'h63;
  localparam logic [7:0]  ChLowR   = 8'h72;
  localparam logic [15:0] CrcPoly  = 16'h1021;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_MISMATCH  = 2'd2,
    ST_TOO_MANY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH,
    OP_PREP,
    OP_DROP,
    OP_CHECK,
    OP_FLUSH,
    OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    GATE_ALWAYS,
    GATE_FIRE,
    GATE_COND,
    GATE_NCOND
  } gate_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_LAST_FIRE,
    COND_EOL_OVER,
    COND_CNT_ZERO,
    COND_TRAILER_BAD,
    COND_UPPER_EMPTY,
    COND_OUT_FREE
  } cond_e;

  localparam logic [PcW-1:0] STEP_ACCEPT = 3'd0;
  localparam logic [PcW-1:0] STEP_PREP   = 3'd1;
  localparam logic [PcW-1:0] STEP_DROP   = 3'd2;
  localparam logic [PcW-1:0] STEP_CHECK  = 3'd3;
  localparam logic [PcW-1:0] STEP_FLUSH  = 3'd4;
  localparam logic [PcW-1:0] STEP_EMIT   = 3'd5;

  typedef struct packed {
    logic             take_in;
    op_e              op;
    gate_e            gate;
    cond_e            cond;
    logic             adv;
    logic [PcW-1:0]   target;
  } ucode_t;

  typedef struct packed {
    logic take_in;
    op_e  op;
    logic en;
  } ctrl_t;

  typedef struct packed {
    logic eol_over;
    logic cnt_zero;
    logic trailer_bad;
    logic upper_empty;
  } flags_t;

  typedef struct packed {
    logic [15:0] claim;
    logic [15:0] comp;
    status_e     status;
  } result_t;

  function automatic ucode_t ucode_rom(logic [PcW-1:0] pc);
    ucode_t w;
    case (pc)
      STEP_ACCEPT: w = '{1'b1, OP_PUSH,  GATE_FIRE,   COND_LAST_FIRE,   1'b0, STEP_PREP};
      STEP_PREP:   w = '{1'b0, OP_PREP,  GATE_ALWAYS, COND_EOL_OVER,    1'b1, STEP_EMIT};
      STEP_DROP:   w = '{1'b0, OP_DROP,  GATE_NCOND,  COND_CNT_ZERO,    1'b0, STEP_CHECK};
      STEP_CHECK:  w = '{1'b0, OP_CHECK, GATE_ALWAYS, COND_TRAILER_BAD, 1'b1, STEP_EMIT};
      STEP_FLUSH:  w = '{1'b0, OP_FLUSH, GATE_NCOND,  COND_UPPER_EMPTY, 1'b0, STEP_EMIT};
      STEP_EMIT:   w = '{1'b0, OP_EMIT,  GATE_COND,   COND_OUT_FREE,    1'b0, STEP_ACCEPT};
      default:     w = '{1'b0, OP_NONE,  GATE_ALWAYS, COND_NEVER,       1'b0, STEP_ACCEPT};
    endcase
    return w;
  endfunction

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_nibble(logic [7:0] d);
    logic [4:0] r;
    r = 5'd0;
    if (d inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(d - 8'h30)};
    end else if (d inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(d - 8'h57)};
    end else if (d inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(d - 8'h37)};
    end
    return r;
  endfunction

endpackage

// File: rtl/core/ctfc_sequencer.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module ctfc_sequencer
  import ctfc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  logic   in_last_i,
  input  logic   out_free_i,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o
);

  logic [PcW-1:0] pc_q, pc_d;
  ucode_t         cw;
  logic           fire;
  logic           cond;
  logic           en;

  always_comb begin
    cw   = ucode_rom(pc_q);
    fire = cw.take_in & in_valid_i;
    case (cw.cond)
      COND_LAST_FIRE:   cond = fire & in_last_i;
      COND_EOL_OVER:    cond = flags_i.eol_over;
      COND_CNT_ZERO:    cond = flags_i.cnt_zero;
      COND_TRAILER_BAD: cond = flags_i.trailer_bad;
      COND_UPPER_EMPTY: cond = flags_i.upper_empty;
      COND_OUT_FREE:    cond = out_free_i;
      default:          cond = 1'b0;
    endcase
    case (cw.gate)
      GATE_FIRE:  en = fire;
      GATE_COND:  en = cond;
      GATE_NCOND: en = ~cond;
      default:    en = 1'b1;
    endcase
    if (cond) begin
      pc_d = cw.target;
    end else if (cw.adv) begin
      pc_d = pc_q + 1'b1;
    end else begin
      pc_d = pc_q;
    end
    ctrl_o = '{take_in: cw.take_in, op: cw.op, en: en};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_ACCEPT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// File: rtl/core/ctfc_datapath.sv
// Datapath: byte delay line with valid bits, CRC unit, counters and trailer check.
module ctfc_datapath
  import ctfc_pkg::*;
#(
  parameter int unsigned MAX_TRAILING_EOL = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_t      ctrl_i,
  input  logic [7:0] frame_byte_i,
  output flags_t     flags_o,
  output result_t    result_o
);

  localparam int unsigned WinLen   = TrailerLen + MAX_TRAILING_EOL;
  localparam int unsigned WinDepth = WinLen + 1;
  localparam int unsigned EolW     = $clog2(MAX_TRAILING_EOL + 2);

  logic [7:0]          win_q [WinDepth];
  logic [7:0]          win_d [WinDepth];
  logic [WinDepth-1:0] vld_q, vld_d;
  logic [EolW-1:0]     eol_q, eol_d;
  logic [EolW-1:0]     cnt_q, cnt_d;
  logic [CountW-1:0]   bcnt_q, bcnt_d;
  logic [15:0]         crc_q, crc_d;
  logic                brace_q, brace_d;
  status_e             status_q, status_d;
  logic [15:0]         claim_q, claim_d;

  logic [7:0]  crc_in;
  logic [15:0] crc_nx;
  logic [4:0]  nib3, nib2, nib1, nib0;
  logic        len_ok, pat_ok, trailer_ok;

  always_comb begin
    crc_in = (ctrl_i.op == OP_PUSH) ? win_q[WinLen-1] : win_q[WinDepth-1];
    crc_nx = crc_byte(crc_q, crc_in);

    nib3 = hex_nibble(win_q[5]);
    nib2 = hex_nibble(win_q[4]);
    nib1 = hex_nibble(win_q[3]);
    nib0 = hex_nibble(win_q[2]);
    len_ok = {1'b0, bcnt_q} >= (6'(eol_q) + 6'(TrailerLen + 1));
    pat_ok = (win_q[12] == ChQuote) && (win_q[11] == ChLowC) && (win_q[10] == ChLowR) &&
             (win_q[9] == ChLowC) && (win_q[8] == ChQuote) && (win_q[7] == ChColon) &&
             (win_q[6] == ChQuote) && (win_q[1] == ChQuote) && (win_q[0] == ChRbrace);
    trailer_ok = len_ok && brace_q && pat_ok && nib3[4] && nib2[4] && nib1[4] && nib0[4];

    flags_o.eol_over    = eol_q > EolW'(MAX_TRAILING_EOL);
    flags_o.cnt_zero    = (cnt_q == '0);
    flags_o.trailer_bad = ~trailer_ok;
    flags_o.upper_empty = ~|vld_q[WinDepth-1:TrailerLen];

    if (status_q == ST_OK) begin
      result_o.status = (crc_q == claim_q) ? ST_OK : ST_MISMATCH;
      result_o.comp   = crc_q;
      result_o.claim  = claim_q;
    end else begin
      result_o.status = status_q;
      result_o.comp   = '0;
      result_o.claim  = '0;
    end
  end

  always_comb begin
    win_d    = win_q;
    vld_d    = vld_q;
    eol_d    = eol_q;
    cnt_d    = cnt_q;
    bcnt_d   = bcnt_q;
    crc_d    = crc_q;
    brace_d  = brace_q;
    status_d = status_q;
    claim_d  = claim_q;
    if (ctrl_i.en) begin
      case (ctrl_i.op)
        OP_PUSH: begin
          for (int i = WinDepth - 1; i > 0; i--) begin
            win_d[i] = win_q[i-1];
            vld_d[i] = vld_q[i-1];
          end
          win_d[0]          = frame_byte_i;
          vld_d[0]          = 1'b1;
          vld_d[WinDepth-1] = 1'b0;
          if (vld_q[WinLen-1]) begin
            crc_d = crc_nx;
          end
          if (bcnt_q == '0) begin
            brace_d = (frame_byte_i == ChLbrace);
          end
          if (bcnt_q != '1) begin
            bcnt_d = bcnt_q + 1'b1;
          end
          if (frame_byte_i inside {ChLf, ChCr}) begin
            if (eol_q <= EolW'(MAX_TRAILING_EOL)) begin
              eol_d = eol_q + 1'b1;
            end
          end else begin
            eol_d = '0;
          end
        end
        OP_PREP: begin
          cnt_d    = eol_q;
          status_d = (eol_q > EolW'(MAX_TRAILING_EOL)) ? ST_TOO_MANY : ST_OK;
        end
        OP_DROP: begin
          for (int i = 0; i < WinDepth - 1; i++) begin
            win_d[i] = win_q[i+1];
            vld_d[i] = vld_q[i+1];
          end
          win_d[WinDepth-1] = '0;
          vld_d[WinDepth-1] = 1'b0;
          cnt_d             = cnt_q - 1'b1;
        end
        OP_CHECK: begin
          status_d = trailer_ok ? ST_OK : ST_MALFORMED;
          claim_d  = {nib3[3:0], nib2[3:0], nib1[3:0], nib0[3:0]};
        end
        OP_FLUSH: begin
          for (int i = WinDepth - 1; i > TrailerLen; i--) begin
            win_d[i] = win_q[i-1];
            vld_d[i] = vld_q[i-1];
          end
          win_d[TrailerLen] = '0;
          vld_d[TrailerLen] = 1'b0;
          if (vld_q[WinDepth-1]) begin
            crc_d = crc_nx;
          end
        end
        OP_EMIT: begin
          vld_d   = '0;
          eol_d   = '0;
          bcnt_d  = '0;
          crc_d   = '0;
          brace_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      eol_q    <= '0;
      cnt_q    <= '0;
      bcnt_q   <= '0;
      crc_q    <= '0;
      brace_q  <= 1'b0;
      status_q <= ST_OK;
      claim_q  <= '0;
    end else begin
      vld_q    <= vld_d;
      eol_q    <= eol_d;
      cnt_q    <= cnt_d;
      bcnt_q   <= bcnt_d;
      crc_q    <= crc_d;
      brace_q  <= brace_d;
      status_q <= status_d;
      claim_q  <= claim_d;
    end
  end

endmodule

// File: rtl/core/crc_trailer_frame_check_unit.sv
// Frame checker for brace-framed text with a "crc":"XXXX"} CRC-16/XMODEM trailer.
// Takes one byte per cycle while a frame streams in; every byte enters a delay line of
// 13 + MAX_TRAILING_EOL bytes and the byte leaving it goes through a one-byte-per-cycle
// CRC unit. After the byte marked tlast a microcoded finish runs: it strips the trailing
// CR/LF bytes one per cycle, checks length, opening brace and trailer in a single step,
// then feeds the held-back prefix bytes through the same CRC unit one per cycle. The
// finish then waits until the output register is free and loads the result into it;
// a new frame is taken as soon as it is loaded. One result transaction per frame:
// status 0 ok, 1 malformed or short, 2 CRC mismatch, 3 too many trailing line ends;
// both CRC values read zero unless the status is 0 or 2.
module crc_trailer_frame_check_unit
  import ctfc_pkg::*;
#(
  parameter int unsigned MAX_TRAILING_EOL = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] frame_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [1:0] status, [17:2] computed_crc,
                                        // [33:18] claimed_crc, [39:34] zero
);

  ctrl_t   ctrl;
  flags_t  flags;
  result_t result;
  logic    out_free;
  logic    emit;
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  assign out_free = ~out_valid_q | m_axis_tready_i;
  assign emit     = ctrl.en && (ctrl.op == OP_EMIT);

  ctfc_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .out_free_i (out_free),
    .flags_i    (flags),
    .ctrl_o     (ctrl)
  );

  ctfc_datapath #(
    .MAX_TRAILING_EOL (MAX_TRAILING_EOL)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .frame_byte_i (s_axis_tdata_i),
    .flags_o      (flags),
    .result_o     (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = result;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign s_axis_tready_o = ctrl.take_in;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_q.claim, out_q.comp, out_q.status};

  a_emit_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("result loaded while output register still held");

  a_finish_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("input taken during end-of-frame finish");

  a_error_zeroes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[1:0] == ST_MALFORMED ||
                         m_axis_tdata_o[1:0] == ST_TOO_MANY))
    |-> (m_axis_tdata_o[33:2] == 32'd0))
    else $error("CRC values reported on a rejected frame");

endmodule
